// ===== sv/sbsi_pkg.sv =====
// Shared types and constants for the swept box slab intersection block.
// Holds only declarations; it has no dependencies.
package sbsi_pkg;

    // Coordinate format: signed fixed point with FB fraction bits.
    localparam int CW = 32;
    localparam int FB = 16;
    // Width of the mover size registers.
    localparam int SW = 31;

    // Slab differences (bound minus position) need three extra bits.
    localparam int DIFF_W = CW + 3;
    // Scaled dividend magnitude.
    localparam int DIV_W = DIFF_W + FB;
    // Quotient magnitude bits produced by the divider.
    localparam int QBITS = CW - 1;
    // Divider register stages: input register, one stage per quotient bit, output register.
    localparam int DIV_LAT = QBITS + 2;
    // Clamp applied to a difference before it is scaled.
    localparam logic [63:0] DIFF_LIM = (64'd1 << (62 - FB)) - 64'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // Normal component codes.
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;

    typedef logic signed [CW-1:0]     t_coord;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [SW-1:0]            t_size;

    // One in the coordinate format.
    localparam t_coord T_ONE = t_coord'(64'd1 << FB);

    // Per-item control that travels beside the dividers.
    typedef struct packed {
        logic [2:0] mv_zero;
        logic [2:0] mv_neg;
        logic       outside;
    } t_side;

endpackage

// ===== sv/swept_box_slab_intersection.sv =====
// Top level of the swept box slab intersection block.
// Depends on sbsi_pkg, sbsi_div and sbsi_select.
//
// One query is taken in every clock cycle (busy stays low) and its result
// leaves on o_valid. The grown slab bounds are formed and registered first,
// then the six slab divisions run one bit per stage between an input and an
// output register, and three register stages reduce the times and pick the
// hit and the normal. The result beat is shown for one cycle only; the
// receiver must take it then. The user must write mover sizes through the
// configuration port only while no query is in flight; the block does not enforce this.
module swept_box_slab_intersection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_move_x,
    input  logic signed [31:0] i_move_y,
    input  logic signed [31:0] i_move_z,
    input  logic signed [31:0] i_target_min_x,
    input  logic signed [31:0] i_target_min_y,
    input  logic signed [31:0] i_target_min_z,
    input  logic signed [31:0] i_target_max_x,
    input  logic signed [31:0] i_target_max_y,
    input  logic signed [31:0] i_target_max_z,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_entry_time,
    output logic signed [1:0]  o_normal_x,
    output logic signed [1:0]  o_normal_y,
    output logic signed [1:0]  o_normal_z
);

    localparam int LAT = sbsi_pkg::DIV_LAT;

    sbsi_pkg::t_size  r_size [3];

    sbsi_pkg::t_coord w_pos  [3];
    sbsi_pkg::t_coord w_mv   [3];
    sbsi_pkg::t_coord w_tmin [3];
    sbsi_pkg::t_coord w_tmax [3];
    sbsi_pkg::t_diff  n_dlo  [3];
    sbsi_pkg::t_diff  n_dhi  [3];
    sbsi_pkg::t_side  n_side;

    logic             r_s1_valid;
    sbsi_pkg::t_diff  r_dlo  [3];
    sbsi_pkg::t_diff  r_dhi  [3];
    sbsi_pkg::t_coord r_mv   [3];
    sbsi_pkg::t_side  r_side;

    logic [LAT-1:0]   r_vpipe;
    sbsi_pkg::t_side  r_spipe [LAT];

    sbsi_pkg::t_coord w_t0 [3];
    sbsi_pkg::t_coord w_t1 [3];

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= '0;
            r_size[1] <= '0;
            r_size[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbsi_pkg::REG_SIZE_X: r_size[0] <= i_cfg_data;
                sbsi_pkg::REG_SIZE_Y: r_size[1] <= i_cfg_data;
                sbsi_pkg::REG_SIZE_Z: r_size[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Grown bounds relative to the mover position.
    always_comb begin
        w_pos  = '{i_pos_x, i_pos_y, i_pos_z};
        w_mv   = '{i_move_x, i_move_y, i_move_z};
        w_tmin = '{i_target_min_x, i_target_min_y, i_target_min_z};
        w_tmax = '{i_target_max_x, i_target_max_y, i_target_max_z};
        n_side = '0;
        for (int a = 0; a < 3; a++) begin
            n_dlo[a] = sbsi_pkg::t_diff'(w_tmin[a])
                     - sbsi_pkg::t_diff'(r_size[a][sbsi_pkg::SW-1:1])
                     - sbsi_pkg::t_diff'(w_pos[a]);
            n_dhi[a] = sbsi_pkg::t_diff'(w_tmax[a])
                     + sbsi_pkg::t_diff'(r_size[a][sbsi_pkg::SW-1:1])
                     - sbsi_pkg::t_diff'(w_pos[a]);
            n_side.mv_zero[a] = (w_mv[a] == '0);
            n_side.mv_neg[a]  = w_mv[a][sbsi_pkg::CW-1];
            if (w_mv[a] == '0 && (n_dlo[a] > 0 || n_dhi[a] < 0)) begin
                n_side.outside = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dlo  <= n_dlo;
        r_dhi  <= n_dhi;
        r_mv   <= w_mv;
        r_side <= n_side;
    end

    // Six slab divisions in parallel.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        sbsi_div u_div_lo (
            .i_clk  (i_clk),
            .i_diff (r_dlo[a]),
            .i_move (r_mv[a]),
            .o_quot (w_t0[a])
        );
        sbsi_div u_div_hi (
            .i_clk  (i_clk),
            .i_diff (r_dhi[a]),
            .i_move (r_mv[a]),
            .o_quot (w_t1[a])
        );
    end

    // Valid and control bits that keep pace with the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[LAT-2:0], r_s1_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_spipe[0] <= r_side;
        for (int k = 1; k < LAT; k++) begin
            r_spipe[k] <= r_spipe[k-1];
        end
    end

    sbsi_select u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_vpipe[LAT-1]),
        .i_side       (r_spipe[LAT-1]),
        .i_t0         (w_t0),
        .i_t1         (w_t1),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_entry_time (o_entry_time),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z)
    );

endmodule

// ===== sv/sbsi_div.sv =====
// Pipelined saturating fixed-point divider: (diff * 2^FB) / move, truncated.
// Depends on sbsi_pkg for widths; one quotient bit per stage.
module sbsi_div (
    input  logic                 i_clk,
    input  sbsi_pkg::t_diff      i_diff,
    input  sbsi_pkg::t_coord     i_move,
    output sbsi_pkg::t_coord     o_quot
);

    localparam int CW    = sbsi_pkg::CW;
    localparam int QBITS = sbsi_pkg::QBITS;
    localparam int HI_W  = sbsi_pkg::DIV_W - QBITS;

    logic [sbsi_pkg::DIFF_W-1:0] w_abs;
    logic [sbsi_pkg::DIFF_W-1:0] w_mag;
    logic [sbsi_pkg::DIV_W-1:0]  w_dvd;
    logic [CW-1:0]               w_mabs;
    logic [HI_W-1:0]             w_hi;
    logic                        w_sat;

    logic [CW-1:0]    r_rem [0:QBITS];
    logic [QBITS-1:0] r_low [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [CW-1:0]    r_m   [0:QBITS];
    logic             r_neg [0:QBITS];
    logic             r_sat [0:QBITS];

    // Magnitudes, clamp and the overflow test that decides saturation.
    always_comb begin
        w_abs = i_diff[sbsi_pkg::DIFF_W-1] ? (~i_diff + 1'b1) : i_diff;
        if ({64'd0, w_abs} > {{sbsi_pkg::DIFF_W{1'b0}}, sbsi_pkg::DIFF_LIM}) begin
            w_mag = w_abs & '0 | sbsi_pkg::DIFF_W'(sbsi_pkg::DIFF_LIM);
        end else begin
            w_mag = w_abs;
        end
        w_dvd  = {w_mag, {sbsi_pkg::FB{1'b0}}};
        w_mabs = i_move[CW-1] ? (~i_move + 1'b1) : i_move;
        w_hi   = w_dvd[sbsi_pkg::DIV_W-1:QBITS];
        w_sat  = (sbsi_pkg::DIV_W'(w_hi) >= sbsi_pkg::DIV_W'(w_mabs));
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= CW'(w_hi);
        r_low[0] <= w_dvd[QBITS-1:0];
        r_q[0]   <= '0;
        r_m[0]   <= w_mabs;
        r_neg[0] <= i_diff[sbsi_pkg::DIFF_W-1] ^ i_move[CW-1];
        r_sat[0] <= w_sat;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic [CW:0] w_sh;
        logic [CW:0] w_sub;
        assign w_sh  = {r_rem[k], r_low[k][QBITS-1]};
        assign w_sub = w_sh - {1'b0, r_m[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_sub[CW] ? w_sh[CW-1:0] : w_sub[CW-1:0];
            r_low[k+1] <= r_low[k] << 1;
            r_q[k+1]   <= {r_q[k][QBITS-2:0], ~w_sub[CW]};
            r_m[k+1]   <= r_m[k];
            r_neg[k+1] <= r_neg[k];
            r_sat[k+1] <= r_sat[k];
        end
    end

    // Sign and saturation.
    always_ff @(posedge i_clk) begin
        if (r_sat[QBITS]) begin
            o_quot <= r_neg[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, {QBITS{1'b1}}};
        end else if (r_neg[QBITS]) begin
            o_quot <= -{1'b0, r_q[QBITS]};
        end else begin
            o_quot <= {1'b0, r_q[QBITS]};
        end
    end

endmodule

// ===== sv/sbsi_select.sv =====
// Slab time reduction, hit test and entry normal selection.
// Depends on sbsi_pkg; three register stages.
module sbsi_select (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  sbsi_pkg::t_side         i_side,
    input  sbsi_pkg::t_coord        i_t0 [3],
    input  sbsi_pkg::t_coord        i_t1 [3],
    output logic                    o_valid,
    output logic                    o_hit,
    output sbsi_pkg::t_coord        o_entry_time,
    output logic signed [1:0]       o_normal_x,
    output logic signed [1:0]       o_normal_y,
    output logic signed [1:0]       o_normal_z
);

    logic             r_v1;
    logic             r_v2;
    sbsi_pkg::t_side  r_side1;
    sbsi_pkg::t_side  r_side2;
    sbsi_pkg::t_coord r_tn1 [3];
    sbsi_pkg::t_coord r_tf1 [3];
    sbsi_pkg::t_coord r_tn2 [3];
    sbsi_pkg::t_coord r_tmin;
    sbsi_pkg::t_coord r_tmax;
    logic             r_have;

    sbsi_pkg::t_coord n_tmin;
    sbsi_pkg::t_coord n_tmax;
    logic             n_have;
    logic             w_hit;
    logic [1:0]       w_axis;
    logic             w_found;
    logic signed [1:0] w_nrm;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // Near and far time of each axis.
    always_ff @(posedge i_clk) begin
        r_side1 <= i_side;
        for (int a = 0; a < 3; a++) begin
            r_tn1[a] <= (i_t0[a] < i_t1[a]) ? i_t0[a] : i_t1[a];
            r_tf1[a] <= (i_t0[a] < i_t1[a]) ? i_t1[a] : i_t0[a];
        end
    end

    // Latest entry and earliest exit over the moving axes.
    always_comb begin
        n_tmin = '0;
        n_tmax = '0;
        n_have = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!r_side1.mv_zero[a]) begin
                if (!n_have) begin
                    n_tmin = r_tn1[a];
                    n_tmax = r_tf1[a];
                end else begin
                    if (r_tn1[a] > n_tmin) n_tmin = r_tn1[a];
                    if (r_tf1[a] < n_tmax) n_tmax = r_tf1[a];
                end
                n_have = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2 <= r_side1;
        r_tn2   <= r_tn1;
        r_tmin  <= n_tmin;
        r_tmax  <= n_tmax;
        r_have  <= n_have;
    end

    // Hit test and first entry axis in x, y, z order.
    always_comb begin
        w_hit = r_have && !r_side2.outside && (r_tmax >= 0) &&
                (r_tmin <= sbsi_pkg::T_ONE) && (r_tmin <= r_tmax);
        w_axis  = 2'd0;
        w_found = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!w_found && !r_side2.mv_zero[a] && r_tn2[a] == r_tmin) begin
                w_axis  = 2'(a);
                w_found = 1'b1;
            end
        end
        w_nrm = r_side2.mv_neg[w_axis] ? sbsi_pkg::NRM_POS : sbsi_pkg::NRM_NEG;
    end

    always_ff @(posedge i_clk) begin
        o_hit        <= w_hit;
        o_entry_time <= r_have ? r_tmin : '0;
        o_normal_x   <= (w_hit && w_found && w_axis == 2'd0) ? w_nrm : sbsi_pkg::NRM_ZERO;
        o_normal_y   <= (w_hit && w_found && w_axis == 2'd1) ? w_nrm : sbsi_pkg::NRM_ZERO;
        o_normal_z   <= (w_hit && w_found && w_axis == 2'd2) ? w_nrm : sbsi_pkg::NRM_ZERO;
    end

endmodule
